@@ design/tmtf_pkg.sv @@
// Shared constants, status codes and unit interface types for the thermistor filter.
// No dependencies; imported by the divider, the log2 unit and the top level.
package tmtf_pkg;

  localparam int SAMPLE_COUNT = 16;
  localparam int IDX_W        = $clog2(SAMPLE_COUNT);
  localparam int CNT_W        = $clog2(SAMPLE_COUNT + 1);
  localparam int MV_W         = 12;
  localparam int SUM_W        = MV_W + CNT_W;
  localparam int MEDIAN_RANK  = SAMPLE_COUNT / 2;

  localparam int NOMINAL_TEMP_CENTI = 2500;
  localparam int KELVIN_OFS         = 27315;
  localparam int T0_CENTI           = NOMINAL_TEMP_CENTI + KELVIN_OFS;
  localparam int T0_X100            = T0_CENTI * 100;
  localparam int TEMP_LOW           = -4000;
  localparam int TEMP_HIGH          = 12500;
  localparam int UNSEEDED_TEMP      = -9900;
  localparam int TK_LOW             = KELVIN_OFS + TEMP_LOW;
  localparam int TK_HIGH            = KELVIN_OFS + TEMP_HIGH;
  localparam int OUTLIER_CENTI      = 1200;
  localparam int OUTLIER_RUN_MAX    = 5;

  localparam int SUPPLY_MV   = 3300;
  localparam int RAIL_LOW_MV = 50;
  localparam int RAIL_HI_MV  = 3250;
  localparam int CODE_MAX    = 4095;
  localparam int R_MIN_OHM   = 100;
  localparam int R_MAX_OHM   = 1000000;

  // avg*4095/3300 = ((avg*273) >> 2) / 55; the /55 is a multiply by
  // ceil(2^25/55) and a shift by 25, exact for the whole 19-bit range
  localparam int RAW_MUL   = 273;
  localparam int RAW_RECIP = 610081;
  localparam int RAW_SHIFT = 25;
  // x/20 as a multiply by ceil(2^22/20) and a shift by 22, exact for x < 2^18
  localparam int DB_RECIP  = 209716;
  localparam int DB_SHIFT  = 22;

  localparam int DIV_W      = 64;
  localparam int LOG_IN_W   = 32;
  localparam int LOG_FRAC_W = 20;
  localparam int LOG_W      = 25;
  localparam int LN2_Q24    = 11629080;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_RAIL = 3'd1;
  localparam logic [2:0] ST_RES  = 3'd2;
  localparam logic [2:0] ST_TEMP = 3'd3;
  localparam logic [2:0] ST_HELD = 3'd4;
  localparam logic [2:0] ST_SEED = 3'd5;

  localparam logic [2:0] CFG_TRIM    = 3'd0;
  localparam logic [2:0] CFG_RFIX    = 3'd1;
  localparam logic [2:0] CFG_RNOM    = 3'd2;
  localparam logic [2:0] CFG_BETA    = 3'd3;
  localparam logic [2:0] CFG_DEADBND = 3'd4;
  localparam logic [2:0] CFG_FASTD   = 3'd5;
  localparam logic [2:0] CFG_ANORM   = 3'd6;
  localparam logic [2:0] CFG_AFAST   = 3'd7;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                start;
    logic [LOG_IN_W-1:0] x;
  } log_req_t;

  typedef struct packed {
    logic             done;
    logic [LOG_W-1:0] result;
  } log_rsp_t;

endpackage

@@ design/tmtf_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tmtf_pkg for widths and request/response types.
module tmtf_div import tmtf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                     busy_r;
  logic                     done_r;
  logic [$clog2(DIV_W)-1:0] cnt_r;
  logic [DIV_W-1:0]         quo_r;
  logic [DIV_W-1:0]         rem_r;
  logic [DIV_W-1:0]         dsr_r;
  logic [DIV_W:0]           trial;
  logic                     fits;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ($clog2(DIV_W))'(DIV_W - 1);
        quo_r  <= req.dividend;
        dsr_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? DIV_W'(trial - {1'b0, dsr_r}) : trial[DIV_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ design/tmtf_log2.sv @@
// log2 in Q20 (fraction truncated): leading-one search, then repeated squaring.
// Depends on tmtf_pkg for widths and request/response types.
module tmtf_log2 import tmtf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  log_req_t req,
  output log_rsp_t rsp
);

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQR, L_ADJ} lstate_t;

  lstate_t                   state_r;
  logic                      done_r;
  logic [LOG_IN_W-1:0]       norm_r;
  logic [4:0]                exp_r;
  logic [LOG_IN_W-2:0]       m_r;
  logic [2*LOG_IN_W-3:0]     prod_r;
  logic [LOG_FRAC_W-1:0]     frac_r;
  logic [4:0]                it_r;
  logic [LOG_IN_W-1:0]       sq;

  // (m*m) >> 30, in [2^30, 2^32)
  assign sq = prod_r[2*LOG_IN_W-3:LOG_IN_W-2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        L_IDLE: begin
          if (req.start) begin
            norm_r  <= req.x;
            exp_r   <= 5'(LOG_IN_W - 1);
            frac_r  <= '0;
            state_r <= L_NORM;
          end
        end
        L_NORM: begin
          if (norm_r[LOG_IN_W-1] || exp_r == '0) begin
            m_r     <= norm_r[LOG_IN_W-1:1];
            it_r    <= '0;
            state_r <= L_SQR;
          end else begin
            norm_r <= {norm_r[LOG_IN_W-2:0], 1'b0};
            exp_r  <= exp_r - 1'b1;
          end
        end
        L_SQR: begin
          prod_r  <= m_r * m_r;
          state_r <= L_ADJ;
        end
        L_ADJ: begin
          frac_r <= {frac_r[LOG_FRAC_W-2:0], sq[LOG_IN_W-1]};
          m_r    <= sq[LOG_IN_W-1] ? sq[LOG_IN_W-1:1] : sq[LOG_IN_W-2:0];
          it_r   <= it_r + 1'b1;
          if (it_r == 5'(LOG_FRAC_W - 1)) begin
            done_r  <= 1'b1;
            state_r <= L_IDLE;
          end else begin
            state_r <= L_SQR;
          end
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = {exp_r, frac_r};

endmodule

@@ design/thermistor_median_trim_filter.sv @@
// Top level: thermistor median/trim filter with Beta-equation conversion.
// Depends on tmtf_pkg, tmtf_div and tmtf_log2.
//
// Usage:
//  in_*  : one millivolt word per accepted cycle (in_valid high, in_stall low).
//          Samples are written into a sample memory at one word per accepted cycle.
//  out_* : one result word per batch of SAMPLE_COUNT samples.
//  cfg_* : register writes, taken at any edge with cfg_we high; write only
//          while the block is idle.
// Processing: once a batch has loaded, in_stall stays high while the batch is
//  processed. The median search sweeps the sample memory once per candidate,
//  the trim average sweeps it once more, and the shared divider runs up to
//  two divisions per batch. Each log2 runs on the shared log2 unit.
// Reset: synchronous, active low; clears the batch, filter state and
//  registers to their defaults. No memory clearing pass is needed.
// Stall: a result waits in the output register while out_stall is high; the
//  next batch can load meanwhile, and its result waits until the slot frees.
module thermistor_median_trim_filter import tmtf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_sample_mv,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] out_temperature_centi,
  output logic               out_reading_valid,
  output logic [11:0]        out_raw_code,
  output logic [2:0]         out_status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_wdata
);

  typedef enum logic [4:0] {
    S_COLLECT, S_CAND, S_RANK, S_TRIM, S_AVG, S_RAWGO, S_RAW, S_RNUM, S_RCHK,
    S_RDEN, S_LOGA, S_LOGB, S_LN, S_TL, S_NUM, S_DEN, S_DCHK, S_TK, S_FILT,
    S_DB, S_DBADD, S_AMUL, S_ADD, S_EMIT
  } state_t;

  // configuration
  logic [11:0] trim_r;
  logic [19:0] rfix_r;
  logic [19:0] rnom_r;
  logic [13:0] beta_r;
  logic [14:0] deadband_r;
  logic [14:0] fastd_r;
  logic [16:0] anorm_r;
  logic [16:0] afast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_r     <= 12'd50;
      rfix_r     <= 20'd10000;
      rnom_r     <= 20'd10000;
      beta_r     <= 14'd3950;
      deadband_r <= 15'd20;
      fastd_r    <= 15'd200;
      anorm_r    <= 17'd6554;
      afast_r    <= 17'd32768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TRIM:    trim_r     <= cfg_wdata[11:0];
        CFG_RFIX:    rfix_r     <= cfg_wdata;
        CFG_RNOM:    rnom_r     <= cfg_wdata;
        CFG_BETA:    beta_r     <= cfg_wdata[13:0];
        CFG_DEADBND: deadband_r <= cfg_wdata[14:0];
        CFG_FASTD:   fastd_r    <= cfg_wdata[14:0];
        CFG_ANORM:   anorm_r    <= cfg_wdata[16:0];
        CFG_AFAST:   afast_r    <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  state_t state_r;
  logic   in_acc;
  assign in_stall = (state_r != S_COLLECT);
  assign in_acc   = in_valid && !in_stall;

  // sample memory
  logic [MV_W-1:0]  mem [SAMPLE_COUNT];
  logic [MV_W-1:0]  rd_data_r;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] cand_idx_r;
  logic [CNT_W-1:0] k_r;

  always_comb begin
    case (state_r)
      S_CAND:         raddr = cand_idx_r;
      S_RANK, S_TRIM: raddr = k_r[IDX_W-1:0];
      default:        raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) mem[idx_r] <= in_sample_mv;
    rd_data_r <= mem[raddr];
  end

  // shared units
  div_req_t div_req_r;
  div_rsp_t div_rsp;
  log_req_t log_req_r;
  log_rsp_t log_rsp;

  tmtf_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req_r), .rsp(div_rsp));
  tmtf_log2 u_log (.clk(clk), .rst_n(rst_n), .req(log_req_r), .rsp(log_rsp));

  // datapath registers
  logic [MV_W-1:0]     cand_r;
  logic [MV_W-1:0]     med_r;
  logic [CNT_W-1:0]    lt_r;
  logic [CNT_W-1:0]    le_r;
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    kept_r;
  logic [MV_W-1:0]     avg_r;
  logic [18:0]         raw_y_r;
  logic [MV_W-1:0]     raw_r;
  logic [31:0]         rnum_r;
  logic [31:0]         rden_r;
  logic [LOG_W-1:0]    l1_r;
  logic [LOG_W-1:0]    l2_r;
  logic                dneg_r;
  logic [48:0]         lnmag_r;
  logic signed [47:0]  tl_r;
  logic [35:0]         num_r;
  logic signed [47:0]  den_r;
  logic signed [15:0]  t_r;
  logic signed [15:0]  filt_r;
  logic                seeded_r;
  logic [2:0]          run_r;
  logic [2:0]          status_r;
  logic                neg_r;
  logic [16:0]         ad_r;
  logic [16:0]         alpha_r;
  logic [33:0]         prod_r;
  logic [35:0]         db_prod_r;

  logic                out_valid_r;
  logic signed [14:0]  out_temp_r;
  logic                out_rv_r;
  logic [11:0]         out_raw_r;
  logic [2:0]          out_status_r;

  // median rank counting
  logic             cmp_en;
  logic             lt_hit;
  logic             le_hit;
  logic [CNT_W-1:0] lt_sum;
  logic [CNT_W-1:0] le_sum;
  logic             last_k;
  assign cmp_en = (k_r != '0);
  assign last_k = (k_r == CNT_W'(SAMPLE_COUNT));
  assign lt_hit = cmp_en && (rd_data_r < cand_r);
  assign le_hit = cmp_en && (rd_data_r <= cand_r);
  assign lt_sum = lt_r + CNT_W'(lt_hit);
  assign le_sum = le_r + CNT_W'(le_hit);

  // trim window
  logic [MV_W-1:0]  dv;
  logic             keep;
  logic [SUM_W-1:0] sum_f;
  logic [CNT_W-1:0] kept_f;
  assign dv     = (rd_data_r > med_r) ? rd_data_r - med_r : med_r - rd_data_r;
  assign keep   = cmp_en && (dv <= trim_r);
  assign sum_f  = sum_r + (keep ? SUM_W'(rd_data_r) : '0);
  assign kept_f = kept_r + CNT_W'(keep);

  // raw code: scale, then reciprocal multiply for the /55
  logic [20:0] raw_x;
  logic [38:0] raw_p;
  logic [13:0] raw_q;
  assign raw_x = 21'(avg_r) * 21'(RAW_MUL);
  assign raw_p = 39'(raw_y_r) * 39'(RAW_RECIP);
  assign raw_q = raw_p[RAW_SHIFT+13:RAW_SHIFT];

  // log difference and ln scaling
  logic signed [26:0] dlog;
  logic [25:0]        dmag;
  logic [28:0]        lmag;
  logic signed [29:0] lval;
  logic signed [46:0] tl_mul;
  assign dlog   = $signed({2'b00, l1_r}) - $signed({2'b00, l2_r});
  assign dmag   = dlog[26] ? 26'(-dlog) : dlog[25:0];
  assign lmag   = lnmag_r[48:20];
  assign lval   = dneg_r ? -$signed({1'b0, lmag}) : $signed({1'b0, lmag});
  assign tl_mul = $signed({1'b0, 16'(T0_CENTI)}) * lval;

  logic [20:0] beta100;
  assign beta100 = 21'(beta_r) * 21'd100;

  // resistance range limits
  logic [31:0] r_lo;
  logic [31:0] r_hi;
  assign r_lo = 32'(avg_r) * 32'(R_MIN_OHM);
  assign r_hi = 32'(avg_r) * 32'(R_MAX_OHM);

  // filter
  logic signed [16:0] delta;
  logic [16:0]        ad;
  logic               outlier;
  logic [2:0]         run_inc;
  assign delta   = 17'(t_r) - 17'(filt_r);
  assign ad      = delta[16] ? 17'(-delta) : delta;
  assign outlier = seeded_r && (ad > 17'(OUTLIER_CENTI));
  assign run_inc = run_r + 1'b1;

  logic [18:0] step_db;
  logic [18:0] step_a;
  logic [34:0] prod_rnd;
  assign step_db  = 19'(db_prod_r[DB_SHIFT+13:DB_SHIFT]);
  assign prod_rnd = 35'(prod_r) + 35'd32768;
  assign step_a   = prod_rnd[34:16];

  function automatic logic signed [15:0] clamp_add(logic signed [15:0] f, logic [18:0] q,
                                                   logic n);
    logic signed [20:0] s;
    logic signed [20:0] stepv;
    stepv = n ? -$signed({2'b00, q}) : $signed({2'b00, q});
    s     = 21'(f) + stepv;
    if (s < 21'(TEMP_LOW)) return 16'(TEMP_LOW);
    if (s > 21'(TEMP_HIGH)) return 16'(TEMP_HIGH);
    return s[15:0];
  endfunction

  logic rejected;
  assign rejected = (status_r == ST_RAIL) || (status_r == ST_RES) || (status_r == ST_TEMP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_COLLECT;
      idx_r           <= '0;
      filt_r          <= '0;
      seeded_r        <= 1'b0;
      run_r           <= '0;
      out_valid_r     <= 1'b0;
      div_req_r.start <= 1'b0;
      log_req_r.start <= 1'b0;
    end else begin
      // start pulses last one cycle; no state raises one while it is high
      if (div_req_r.start) div_req_r.start <= 1'b0;
      if (log_req_r.start) log_req_r.start <= 1'b0;
      if (out_valid_r && !out_stall && state_r != S_EMIT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_COLLECT: begin
          if (in_acc) begin
            if (idx_r == IDX_W'(SAMPLE_COUNT - 1)) begin
              idx_r      <= '0;
              cand_idx_r <= '0;
              state_r    <= S_CAND;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_CAND: begin
          k_r     <= '0;
          lt_r    <= '0;
          le_r    <= '0;
          state_r <= S_RANK;
        end
        S_RANK: begin
          if (!cmp_en) cand_r <= rd_data_r;
          lt_r <= lt_sum;
          le_r <= le_sum;
          if (last_k) begin
            // candidate is the median when its rank covers the middle slot
            if (lt_sum <= CNT_W'(MEDIAN_RANK) && le_sum > CNT_W'(MEDIAN_RANK)) begin
              med_r   <= cand_r;
              k_r     <= '0;
              sum_r   <= '0;
              kept_r  <= '0;
              state_r <= S_TRIM;
            end else begin
              cand_idx_r <= cand_idx_r + 1'b1;
              state_r    <= S_CAND;
            end
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_TRIM: begin
          sum_r  <= sum_f;
          kept_r <= kept_f;
          if (last_k) begin
            if (kept_f == '0) begin
              avg_r   <= med_r;
              state_r <= S_RAWGO;
            end else begin
              div_req_r.start    <= 1'b1;
              div_req_r.dividend <= DIV_W'(sum_f);
              div_req_r.divisor  <= DIV_W'(kept_f);
              state_r            <= S_AVG;
            end
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_AVG: begin
          if (div_rsp.done) begin
            avg_r   <= div_rsp.quotient[MV_W-1:0];
            state_r <= S_RAWGO;
          end
        end
        S_RAWGO: begin
          raw_y_r <= raw_x[20:2];
          state_r <= S_RAW;
        end
        S_RAW: begin
          raw_r <= (raw_q > 14'(CODE_MAX)) ? 12'(CODE_MAX) : raw_q[11:0];
          if (avg_r <= 12'(RAIL_LOW_MV) || avg_r >= 12'(RAIL_HI_MV)) begin
            status_r <= ST_RAIL;
            state_r  <= S_EMIT;
          end else begin
            state_r <= S_RNUM;
          end
        end
        S_RNUM: begin
          rnum_r  <= 32'(rfix_r) * 32'(12'(SUPPLY_MV) - avg_r);
          state_r <= S_RCHK;
        end
        S_RCHK: begin
          if (rnum_r < r_lo || rnum_r > r_hi) begin
            status_r <= ST_RES;
            state_r  <= S_EMIT;
          end else if (rnom_r == '0 || beta_r == '0) begin
            status_r <= ST_TEMP;
            state_r  <= S_EMIT;
          end else begin
            state_r <= S_RDEN;
          end
        end
        S_RDEN: begin
          rden_r          <= 32'(avg_r) * 32'(rnom_r);
          log_req_r.start <= 1'b1;
          log_req_r.x     <= rnum_r;
          state_r         <= S_LOGA;
        end
        S_LOGA: begin
          if (log_rsp.done) begin
            l1_r            <= log_rsp.result;
            log_req_r.start <= 1'b1;
            log_req_r.x     <= rden_r;
            state_r         <= S_LOGB;
          end
        end
        S_LOGB: begin
          if (log_rsp.done) begin
            l2_r    <= log_rsp.result;
            state_r <= S_LN;
          end
        end
        S_LN: begin
          dneg_r  <= dlog[26];
          lnmag_r <= 49'(dmag[24:0]) * 49'(LN2_Q24);
          state_r <= S_TL;
        end
        S_TL: begin
          tl_r    <= {tl_mul[46], tl_mul};
          state_r <= S_NUM;
        end
        S_NUM: begin
          num_r   <= 36'(beta_r) * 36'(T0_X100);
          state_r <= S_DEN;
        end
        S_DEN: begin
          den_r   <= $signed({3'b000, beta100, 24'd0}) + tl_r;
          state_r <= S_DCHK;
        end
        S_DCHK: begin
          if (den_r[47] || den_r == '0) begin
            status_r <= ST_TEMP;
            state_r  <= S_EMIT;
          end else begin
            // round to nearest: (num + den/2) / den
            div_req_r.start    <= 1'b1;
            div_req_r.dividend <= {4'd0, num_r, 24'd0} + {17'd0, den_r[47:1]};
            div_req_r.divisor  <= DIV_W'(den_r);
            state_r            <= S_TK;
          end
        end
        S_TK: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient < DIV_W'(TK_LOW) || div_rsp.quotient > DIV_W'(TK_HIGH)) begin
              status_r <= ST_TEMP;
              state_r  <= S_EMIT;
            end else begin
              t_r     <= 16'(div_rsp.quotient[15:0] - 16'(KELVIN_OFS));
              state_r <= S_FILT;
            end
          end
        end
        S_FILT: begin
          neg_r <= delta[16];
          if (outlier && run_inc < 3'(OUTLIER_RUN_MAX)) begin
            run_r    <= run_inc;
            status_r <= ST_HELD;
            state_r  <= S_EMIT;
          end else begin
            run_r <= '0;
            if (!seeded_r) begin
              filt_r   <= t_r;
              seeded_r <= 1'b1;
              status_r <= ST_SEED;
              state_r  <= S_EMIT;
            end else if (ad < 17'(deadband_r)) begin
              // slow fixed gain: delta/20, rounded half away from zero
              status_r <= ST_OK;
              ad_r     <= ad + 17'd10;
              state_r  <= S_DB;
            end else begin
              status_r <= ST_OK;
              alpha_r  <= (ad > 17'(fastd_r)) ? afast_r : anorm_r;
              ad_r     <= ad;
              state_r  <= S_AMUL;
            end
          end
        end
        S_DB: begin
          db_prod_r <= 36'(ad_r) * 36'(DB_RECIP);
          state_r   <= S_DBADD;
        end
        S_DBADD: begin
          filt_r  <= clamp_add(filt_r, step_db, neg_r);
          state_r <= S_EMIT;
        end
        S_AMUL: begin
          prod_r  <= ad_r * alpha_r;
          state_r <= S_ADD;
        end
        S_ADD: begin
          filt_r  <= clamp_add(filt_r, step_a, neg_r);
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_temp_r   <= (rejected && !seeded_r) ? 15'(UNSEEDED_TEMP) : filt_r[14:0];
            out_rv_r     <= !rejected;
            out_raw_r    <= raw_r;
            out_status_r <= status_r;
            state_r      <= S_COLLECT;
          end
        end
        default: state_r <= S_COLLECT;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = out_temp_r;
  assign out_reading_valid     = out_rv_r;
  assign out_raw_code          = out_raw_r;
  assign out_status            = out_status_r;

endmodule

@@ verif/thermistor_median_trim_filter_tb.sv @@
// Testbench for thermistor_median_trim_filter: batches of millivolt words in,
// one filtered temperature word out per batch, checked against a local model.
// Depends on tmtf_pkg and the design sources.
`timescale 1ns / 100ps

module thermistor_median_trim_filter_tb;
  import tmtf_pkg::*;

  typedef struct packed {
    logic signed [14:0] temp;
    logic               rvalid;
    logic [11:0]        code;
    logic [2:0]         status;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [11:0] in_sample_mv = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [14:0] out_temperature_centi;
  logic out_reading_valid;
  logic [11:0] out_raw_code;
  logic [2:0] out_status;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_wdata = '0;

  thermistor_median_trim_filter i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model registers and state
  longint trim_mv, rfix, rnom, beta, deadband, fast_delta, a_norm, a_fast;
  logic [11:0] batch[SAMPLE_COUNT];
  int batch_fill;
  longint filt_temp;
  bit seeded;
  int held_run;

  logic [11:0] word_queue[$];
  reading_t expected_readings[$];
  int fail_count;
  bit recv_hold;     // long receiver hold-off
  bit recv_holding;
  longint cycle_count;

  function automatic longint log2_q20(longint unsigned x);
    longint unsigned t, m;
    longint e, frac;
    t = x; e = 0; frac = 0;
    while (t > 1) begin
      t >>= 1;
      e++;
    end
    m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
    for (int i = 0; i < 20; i++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        frac |= 1;
      end
    end
    return e * 1048576 + frac;
  endfunction

  function automatic longint div_half_away(longint v, longint d);
    longint mag;
    mag = v < 0 ? -v : v;
    mag = (mag + d / 2) / d;
    return v < 0 ? -mag : mag;
  endfunction

  function automatic longint clamp_centi(longint v);
    if (v < TEMP_LOW) return TEMP_LOW;
    if (v > TEMP_HIGH) return TEMP_HIGH;
    return v;
  endfunction

  function automatic logic [2:0] mv_to_centi(longint mv, output longint tc);
    longint unsigned rnum, rden;
    longint d, mag, l, t0, num, den, tk;
    tc = 0;
    if (mv <= RAIL_LOW_MV || mv >= RAIL_HI_MV) return ST_RAIL;
    rnum = rfix * (SUPPLY_MV - mv);
    if (rnum < 100 * mv || rnum > 1000000 * mv) return ST_RES;
    if (rnom == 0 || beta == 0) return ST_TEMP;
    rden = mv * rnom;
    d = log2_q20(rnum) - log2_q20(rden);
    mag = ((d < 0 ? -d : d) * LN2_Q24) >>> 20;
    l = d < 0 ? -mag : mag;
    t0 = T0_CENTI;
    if (t0 <= 0) return ST_TEMP;
    den = 100 * beta * 16777216 + t0 * l;
    if (den <= 0) return ST_TEMP;
    num = 100 * t0 * beta * 16777216;
    tk = (num + den / 2) / den - KELVIN_OFS;
    if (tk < TEMP_LOW || tk > TEMP_HIGH) return ST_TEMP;
    tc = tk;
    return ST_OK;
  endfunction

  // adds one sample; at batch end pushes the expected reading
  task automatic filter_sample(logic [11:0] mv);
    logic [11:0] s[SAMPLE_COUNT];
    logic [11:0] v;
    longint med, sum, kept, avg, raw, t, delta, ad, alpha, dv;
    int j;
    logic [2:0] st;
    reading_t r;
    batch[batch_fill] = mv;
    batch_fill++;
    if (batch_fill < SAMPLE_COUNT) return;
    batch_fill = 0;
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      v = batch[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    med = s[MEDIAN_RANK];
    sum = 0; kept = 0;
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      dv = s[i] > med ? s[i] - med : med - s[i];
      if (dv <= trim_mv) begin
        sum += s[i];
        kept++;
      end
    end
    avg = kept ? sum / kept : med;
    raw = avg * 4095 / SUPPLY_MV;
    if (raw > CODE_MAX) raw = CODE_MAX;
    st = mv_to_centi(avg, t);
    r.code = raw[11:0];
    if (st != ST_OK) begin
      r.rvalid = 1'b0;
      r.temp = seeded ? filt_temp[14:0] : 15'(UNSEEDED_TEMP);
    end else begin
      delta = t - filt_temp;
      ad = delta < 0 ? -delta : delta;
      r.rvalid = 1'b1;
      if (seeded && ad > OUTLIER_CENTI) begin
        held_run++;
        if (held_run < OUTLIER_RUN_MAX) st = ST_HELD;
        else held_run = 0;
      end else begin
        held_run = 0;
      end
      if (st != ST_HELD) begin
        if (!seeded) begin
          filt_temp = t;
          seeded = 1'b1;
          st = ST_SEED;
        end else if (ad < deadband) begin
          filt_temp = clamp_centi(filt_temp + div_half_away(delta, 20));
        end else begin
          alpha = ad > fast_delta ? a_fast : a_norm;
          filt_temp = clamp_centi(filt_temp + div_half_away(delta * alpha, 65536));
        end
      end
      r.temp = filt_temp[14:0];
    end
    r.status = st;
    expected_readings.push_back(r);
  endtask

  // input word taken at the last rising edge
  bit in_taken;
  always @(posedge clk) in_taken <= in_valid && !in_stall;

  // driver
  int send_gap;
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_valid) begin
        filter_sample(in_sample_mv);
        void'(word_queue.pop_front());
      end
      if (send_gap > 0 || word_queue.size() == 0) begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end else begin
        in_valid <= 1'b1;
        in_sample_mv <= word_queue[0];
        send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
      end
    end
  end

  // receiver stall
  int recv_gap;
  int hold_cycles;
  always @(negedge clk) begin
    if (rst_n) begin
      if (recv_hold && !recv_holding) begin
        recv_holding = 1'b1;
        hold_cycles = 6000;
      end
      if (recv_holding) begin
        out_stall <= 1'b1;
        hold_cycles--;
        if (hold_cycles == 0) begin
          recv_holding = 1'b0;
          recv_hold = 1'b0;
        end
      end else if (recv_gap > 0) begin
        out_stall <= 1'b1;
        recv_gap--;
      end else begin
        out_stall <= 1'b0;
        recv_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reading_t e;
    cycle_count++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected result word");
        fail_count++;
      end else begin
        e = expected_readings.pop_front();
        if (out_temperature_centi !== e.temp) begin
          $error("temperature_centi exp %0d got %0d", e.temp, out_temperature_centi);
          fail_count++;
        end
        if (out_reading_valid !== e.rvalid) begin
          $error("reading_valid exp %0d got %0d", e.rvalid, out_reading_valid);
          fail_count++;
        end
        if (out_raw_code !== e.code) begin
          $error("raw_code exp %0d got %0d", e.code, out_raw_code);
          fail_count++;
        end
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status);
          fail_count++;
        end
      end
    end
    if (cycle_count > 2500000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, longint val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[19:0];
    case (idx)
      CFG_TRIM:    trim_mv = val & 12'hFFF;
      CFG_RFIX:    rfix = val & 20'hFFFFF;
      CFG_RNOM:    rnom = val & 20'hFFFFF;
      CFG_BETA:    beta = val & 14'h3FFF;
      CFG_DEADBND: deadband = val & 15'h7FFF;
      CFG_FASTD:   fast_delta = val & 15'h7FFF;
      CFG_ANORM:   a_norm = val & 17'h1FFFF;
      default:     a_fast = val & 17'h1FFFF;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait for all words taken and all readings out, then the pipeline drain
  task automatic drain();
    while (word_queue.size() > 0 || in_valid || expected_readings.size() > 0)
      @(negedge clk);
    repeat (1000) @(negedge clk);
  endtask

  // a batch around a center voltage with spread and some wild samples
  task automatic queue_batch(int center, int spread, int wild);
    int v;
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      if ($urandom_range(0, 99) < wild) v = $urandom_range(0, 4095);
      else v = center + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      word_queue.push_back(v[11:0]);
    end
  endtask

  task automatic random_batches(int n);
    int c;
    for (int b = 0; b < n; b++) begin
      case ($urandom_range(0, 9))
        0: queue_batch($urandom_range(0, 4095), 4095, 0);
        1: queue_batch($urandom_range(0, 120), 40, 5);
        2: queue_batch($urandom_range(3180, 3400), 40, 5);
        default: begin
          c = 1000 + $urandom_range(0, 1300);
          queue_batch(c, $urandom_range(0, 80), $urandom_range(0, 20));
        end
      endcase
    end
  endtask

  initial begin
    trim_mv = 50; rfix = 10000; rnom = 10000; beta = 3950;
    deadband = 20; fast_delta = 200; a_norm = 6554; a_fast = 32768;
    batch_fill = 0; filt_temp = 0; seeded = 0; held_run = 0;
    fail_count = 0; cycle_count = 0; recv_hold = 0; recv_holding = 0;
    send_gap = 0; recv_gap = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: rails, extremes, unseeded rejection, seeding, outlier run
    queue_batch(0, 0, 0);
    queue_batch(4095, 0, 0);
    queue_batch(1650, 0, 0);
    for (int k = 0; k < 6; k++) queue_batch(k < 5 ? 300 : 1650, 0, 0);
    drain();

    // long receiver hold-off so the block backs up
    recv_hold = 1'b1;
    random_batches(8);
    drain();

    write_reg(CFG_TRIM, 0);
    write_reg(CFG_RFIX, 1000000);
    write_reg(CFG_RNOM, 1);
    write_reg(CFG_BETA, 10000);
    write_reg(CFG_DEADBND, 0);
    write_reg(CFG_FASTD, 16500);
    write_reg(CFG_ANORM, 65536);
    write_reg(CFG_AFAST, 0);
    random_batches(20);
    drain();

    write_reg(CFG_TRIM, 4095);
    write_reg(CFG_RFIX, 1);
    write_reg(CFG_RNOM, 1000000);
    write_reg(CFG_BETA, 1000);
    write_reg(CFG_DEADBND, 16500);
    write_reg(CFG_FASTD, 0);
    write_reg(CFG_ANORM, 0);
    write_reg(CFG_AFAST, 65536);
    random_batches(10);
    drain();

    // zero resistor, zero beta, alpha above one
    write_reg(CFG_RFIX, 0);
    write_reg(CFG_BETA, 0);
    write_reg(CFG_ANORM, 131071);
    write_reg(CFG_AFAST, 131071);
    random_batches(4);
    drain();
    write_reg(CFG_RFIX, 10000);
    write_reg(CFG_RNOM, 0);
    write_reg(CFG_BETA, 3950);
    write_reg(CFG_DEADBND, 5);
    write_reg(CFG_FASTD, 50);
    random_batches(6);
    drain();

    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_TRIM, $urandom_range(0, 200));
      write_reg(CFG_RFIX, $urandom_range(1000, 100000));
      write_reg(CFG_RNOM, $urandom_range(1000, 100000));
      write_reg(CFG_BETA, $urandom_range(1000, 10000));
      write_reg(CFG_DEADBND, $urandom_range(0, 300));
      write_reg(CFG_FASTD, $urandom_range(0, 2000));
      write_reg(CFG_ANORM, $urandom_range(0, 65536));
      write_reg(CFG_AFAST, $urandom_range(0, 65536));
      random_batches(6);
      drain();
    end

    write_reg(CFG_TRIM, 50);
    write_reg(CFG_RFIX, 10000);
    write_reg(CFG_RNOM, 10000);
    write_reg(CFG_DEADBND, 20);
    write_reg(CFG_FASTD, 200);
    write_reg(CFG_ANORM, 6554);
    write_reg(CFG_AFAST, 32768);
    random_batches(16);
    drain();

    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ sim.f @@
design/tmtf_pkg.sv
design/tmtf_div.sv
design/tmtf_log2.sv
design/thermistor_median_trim_filter.sv
verif/thermistor_median_trim_filter_tb.sv
